### rtl/spq_pkg.sv
// Shared types and constants for the strict priority queue with ECN marking.
// No dependencies.
package spq_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MTHRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LTHRESH = 3'd4;

    localparam logic [1:0] MODE_QUEUE   = 2'd0;
    localparam logic [1:0] MODE_PORT    = 2'd1;
    localparam logic [1:0] MODE_LATENCY = 2'd2;
    localparam logic [1:0] MODE_OFF     = 2'd3;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam int BYTES_W = 24;

    typedef struct packed {
        logic        req_type;
        logic [15:0] packet_id;
        logic [7:0]  class_in;
        logic [15:0] pkt_bytes;
        logic        ect_in;
        logic        ce_in;
        logic [31:0] now_ticks;
    } req_t;

    typedef struct packed {
        logic              enq_accepted;
        logic              deq_valid;
        logic [15:0]       packet_id_out;
        logic [2:0]        class_out;
        logic [15:0]       bytes_out;
        logic              ce_out;
        logic [BYTES_W-1:0] total_bytes_out;
    } rsp_t;

    typedef struct packed {
        logic [3:0]         active_classes;
        logic [BYTES_W-1:0] limit_bytes;
        logic [BYTES_W-1:0] mark_thresh_bytes;
        logic [1:0]         marking_mode;
        logic [31:0]        latency_thresh_ticks;
    } cfg_t;

endpackage

### rtl/spq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/spq_front.sv
// Front end: config registers, input acceptance into a two-entry request queue.
// Depends on spq_pkg.
module spq_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [spq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    output spq_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  spq_pkg::req_t             in_req,
    output logic                      q_valid,
    input  logic                      q_ready,
    output spq_pkg::req_t             q_req
);

    spq_pkg::cfg_t cfg_reg;
    spq_pkg::req_t buf_reg [2];
    logic [1:0]    cnt_reg;
    logic          rd_reg, wr_reg;
    logic          push, pop;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_classes       <= 4'd8;
            cfg_reg.limit_bytes          <= 24'd75000;
            cfg_reg.mark_thresh_bytes    <= 24'd97500;
            cfg_reg.marking_mode         <= spq_pkg::MODE_QUEUE;
            cfg_reg.latency_thresh_ticks <= 32'd78000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                spq_pkg::REG_ACTIVE:  cfg_reg.active_classes <= cfg_data[3:0];
                spq_pkg::REG_LIMIT:   cfg_reg.limit_bytes <= cfg_data[23:0];
                spq_pkg::REG_MTHRESH: cfg_reg.mark_thresh_bytes <= cfg_data[23:0];
                spq_pkg::REG_MODE:    cfg_reg.marking_mode <= cfg_data[1:0];
                spq_pkg::REG_LTHRESH: cfg_reg.latency_thresh_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_req    = buf_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### rtl/spq_back.sv
// Back end: per-class FIFO bookkeeping, drop/mark decisions, descriptor RAMs.
// Depends on spq_pkg and spq_ram.
module spq_back #(
    parameter int NUM_CLASSES = 8,
    parameter int FIFO_DEPTH  = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  spq_pkg::cfg_t cfg,
    input  logic          q_valid,
    output logic          q_ready,
    input  spq_pkg::req_t q_req,
    output logic          out_valid,
    input  logic          out_ready,
    output spq_pkg::rsp_t out_rsp
);

    localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PW    = $clog2(FIFO_DEPTH);
    localparam int NW    = $clog2(FIFO_DEPTH + 1);
    localparam int SLOTS = NUM_CLASSES * FIFO_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int BW    = spq_pkg::BYTES_W;
    localparam int DW    = 34;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]    state_reg, state_next;
    spq_pkg::req_t req_reg;
    spq_pkg::rsp_t rsp_reg, rsp_next;
    logic [CW-1:0] sel_reg, sel_next;

    logic [PW-1:0] head_reg [NUM_CLASSES];
    logic [PW-1:0] tail_reg [NUM_CLASSES];
    logic [NW-1:0] count_reg [NUM_CLASSES];
    logic [BW-1:0] cbytes_reg [NUM_CLASSES];
    logic [BW-1:0] total_reg;

    logic [4:0]    act;
    logic [CW-1:0] ecls;
    logic          found;
    logic [CW-1:0] fcls;
    logic [BW:0]   tsum, csum;
    logic          enq_ok, mark;
    logic [BW-1:0] new_c, new_t;
    logic          take;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] drd;
    logic [31:0]   srd;
    logic [15:0]   blen;
    logic [31:0]   soj;

    always_comb
    begin
        if (cfg.active_classes == 4'd0)
        begin
            act = 5'd1;
        end
        else if ({1'b0, cfg.active_classes} > 5'(NUM_CLASSES))
        begin
            act = 5'(NUM_CLASSES);
        end
        else
        begin
            act = {1'b0, cfg.active_classes};
        end
        if ({1'b0, req_reg.class_in} >= 9'(act))
        begin
            ecls = CW'(act - 5'd1);
        end
        else
        begin
            ecls = CW'(req_reg.class_in);
        end
    end

    always_comb
    begin
        found = 1'b0;
        fcls  = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (5'(i) < act && count_reg[i] != '0)
            begin
                found = 1'b1;
                fcls  = CW'(i);
            end
        end
    end

    assign tsum   = {1'b0, total_reg} + (BW+1)'(req_reg.pkt_bytes);
    assign csum   = {1'b0, cbytes_reg[ecls]} + (BW+1)'(req_reg.pkt_bytes);
    assign enq_ok = (tsum <= (BW+1)'(cfg.limit_bytes)) &&
                    (count_reg[ecls] < NW'(FIFO_DEPTH));
    assign mark   = req_reg.ect_in &&
                    ((cfg.marking_mode == spq_pkg::MODE_QUEUE &&
                      csum[BW-1:0] > cfg.mark_thresh_bytes) ||
                     (cfg.marking_mode == spq_pkg::MODE_PORT &&
                      tsum[BW-1:0] > cfg.mark_thresh_bytes));

    assign take    = (state_reg == ST_IDLE) && q_valid;
    assign q_ready = (state_reg == ST_IDLE);

    assign we    = (state_reg == ST_READ) && req_reg.req_type == spq_pkg::REQ_ENQ && enq_ok;
    assign waddr = AW'(ecls) * AW'(FIFO_DEPTH) + AW'(tail_reg[ecls]);
    assign re    = (state_reg == ST_READ) && req_reg.req_type == spq_pkg::REQ_DEQ;
    assign raddr = AW'(fcls) * AW'(FIFO_DEPTH) + AW'(head_reg[fcls]);

    spq_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_desc (
        .clk(clk), .we(we), .waddr(waddr),
        .wdata({req_reg.ce_in | mark, req_reg.ect_in, req_reg.pkt_bytes, req_reg.packet_id}),
        .re(re), .raddr(raddr), .rdata(drd)
    );

    spq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_stamp (
        .clk(clk), .we(we), .waddr(waddr), .wdata(req_reg.now_ticks),
        .re(re), .raddr(raddr), .rdata(srd)
    );

    assign blen  = drd[31:16];
    assign soj   = req_reg.now_ticks - srd;
    assign new_c = (cbytes_reg[sel_reg] >= BW'(blen)) ? cbytes_reg[sel_reg] - BW'(blen) : '0;
    assign new_t = (total_reg >= BW'(blen)) ? total_reg - BW'(blen) : '0;

    always_comb
    begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rsp_next = '0;
                if (req_reg.req_type == spq_pkg::REQ_ENQ)
                begin
                    rsp_next.class_out = 3'(ecls);
                    rsp_next.ce_out    = req_reg.ce_in;
                    rsp_next.total_bytes_out = total_reg;
                    if (enq_ok)
                    begin
                        rsp_next.enq_accepted    = 1'b1;
                        rsp_next.ce_out          = req_reg.ce_in | mark;
                        rsp_next.total_bytes_out = tsum[BW-1:0];
                    end
                    state_next = ST_OUT;
                end
                else if (found)
                begin
                    sel_next   = fcls;
                    state_next = ST_POP;
                end
                else
                begin
                    rsp_next.total_bytes_out = total_reg;
                    state_next = ST_OUT;
                end
            end
            ST_POP:
            begin
                rsp_next.deq_valid       = 1'b1;
                rsp_next.packet_id_out   = drd[15:0];
                rsp_next.class_out       = 3'(sel_reg);
                rsp_next.bytes_out       = blen;
                rsp_next.ce_out          = drd[33] |
                    (cfg.marking_mode == spq_pkg::MODE_LATENCY && drd[32] &&
                     soj > cfg.latency_thresh_ticks);
                rsp_next.total_bytes_out = new_t;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = (state_reg == ST_OUT);
    assign out_rsp   = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= q_req;
        end
        rsp_reg <= rsp_next;
        sel_reg <= sel_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i]   <= '0;
                tail_reg[i]   <= '0;
                count_reg[i]  <= '0;
                cbytes_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (we)
            begin
                cbytes_reg[ecls] <= csum[BW-1:0];
                total_reg        <= tsum[BW-1:0];
                count_reg[ecls]  <= count_reg[ecls] + NW'(1);
                tail_reg[ecls]   <= (32'(tail_reg[ecls]) + 1 >= FIFO_DEPTH) ? '0
                                    : tail_reg[ecls] + PW'(1);
            end
            if (state_reg == ST_POP)
            begin
                cbytes_reg[sel_reg] <= new_c;
                total_reg           <= new_t;
                count_reg[sel_reg]  <= count_reg[sel_reg] - NW'(1);
                head_reg[sel_reg]   <= (32'(head_reg[sel_reg]) + 1 >= FIFO_DEPTH) ? '0
                                       : head_reg[sel_reg] + PW'(1);
            end
        end
    end

endmodule

### rtl/strict_priority_queue_ecn_top.sv
// Strict priority queue with ECN marking: the back end steps IDLE, READ, OUT for an enqueue or empty dequeue,
// and IDLE, READ, POP, OUT for a dequeue with a pop; it takes a new request only after its result is taken.
// A two-entry request queue takes items while the back end works.
// Asynchronous active-low reset empties all class FIFOs and restores register defaults.
// Depends on spq_pkg, spq_front, spq_back.
module strict_priority_queue_ecn_top #(
    parameter int NUM_CLASSES = 8,
    parameter int FIFO_DEPTH  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // packet_id, class_in, pkt_bytes, ect_in, ce_in, now_ticks, pad
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // packet_id_out, class_out, bytes_out, ce_out, total_bytes_out, pad
    output logic [1:0]  m_axis_tuser   // enq_accepted, deq_valid
);

    spq_pkg::cfg_t cfg;
    spq_pkg::req_t in_req, q_req;
    spq_pkg::rsp_t rsp;
    logic          q_valid, q_ready;

    assign in_req.req_type  = s_axis_tuser;
    assign in_req.packet_id = s_axis_tdata[15:0];
    assign in_req.class_in  = s_axis_tdata[23:16];
    assign in_req.pkt_bytes = s_axis_tdata[39:24];
    assign in_req.ect_in    = s_axis_tdata[40];
    assign in_req.ce_in     = s_axis_tdata[41];
    assign in_req.now_ticks = s_axis_tdata[73:42];

    spq_front u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    spq_back #(.NUM_CLASSES(NUM_CLASSES), .FIFO_DEPTH(FIFO_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp)
    );

    assign m_axis_tuser = {rsp.deq_valid, rsp.enq_accepted};
    assign m_axis_tdata = {4'd0, rsp.total_bytes_out, rsp.ce_out, rsp.bytes_out,
                           rsp.class_out, rsp.packet_id_out};

endmodule

### rtl/spq_checker.sv
// Port-level checker for the strict priority queue top level, with its bind.
// Depends on strict_priority_queue_ecn_top.
module spq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("enq and deq flags both set");

    a_empty_deq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[1]) |->
        m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[34:19] == 16'd0)
        else $error("empty result carries payload");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && !s_axis_tready) |=> s_axis_tvalid && $stable(s_axis_tuser))
        else $error("input transaction withdrawn while stalled");

    a_no_out_after_reset: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind strict_priority_queue_ecn_top spq_checker u_spq_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
